/* src/bounded_stack_with_insert_unit_assert.svh */
// ----------------------------------------------------------------------------
// Stack assertion macros
// Implication checks for the stack unit, removed when SYNTHESIS is defined.
// ----------------------------------------------------------------------------
`ifndef BOUNDED_STACK_WITH_INSERT_UNIT_ASSERT_SVH
`define BOUNDED_STACK_WITH_INSERT_UNIT_ASSERT_SVH

`ifndef SYNTHESIS

`define BSI_ASSERT_SAME(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("stack check failed");

`define BSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("stack check failed");

`else

`define BSI_ASSERT_SAME(lbl, clk, rstn, ante, cons)

`define BSI_ASSERT_NEXT(lbl, clk, rstn, ante, cons)

`endif

`endif

/* src/bsi_pkg.sv */
// ----------------------------------------------------------------------------
// Stack unit package
// Sizes, operation codes and status codes shared by the stack unit files.
// ----------------------------------------------------------------------------
package bsi_pkg;

	localparam int DEPTH  = 128;
	localparam int ADDR_W = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;

	typedef logic signed [WORD_W-1:0] word_t;
	typedef logic [1:0]               opcode_t;
	typedef logic [1:0]               status_t;
	typedef logic [6:0]               position_t;
	typedef logic [7:0]               entry_count_t;

	localparam opcode_t OP_PUSH   = 2'd0;
	localparam opcode_t OP_POP    = 2'd1;
	localparam opcode_t OP_INSERT = 2'd2;
	localparam opcode_t OP_QUERY  = 2'd3;

	localparam status_t ST_OK        = 2'd0;
	localparam status_t ST_OVERFLOW  = 2'd1;
	localparam status_t ST_UNDERFLOW = 2'd2;

	localparam word_t EMPTY_WORD = '1;

endpackage

/* src/bsi_req_if.sv */
// ----------------------------------------------------------------------------
// Stack request channel
// Valid/ready channel carrying one stack operation.
// ----------------------------------------------------------------------------
interface bsi_req_if;
	import bsi_pkg::*;

	logic      valid;
	logic      ready;
	opcode_t   opcode;
	word_t     value;
	position_t position;

	modport source (output valid, output opcode, output value, output position, input ready);
	modport sink (input valid, input opcode, input value, input position, output ready);

endinterface

/* src/bsi_res_if.sv */
// ----------------------------------------------------------------------------
// Stack result channel
// Valid/ready channel carrying one stack result.
// ----------------------------------------------------------------------------
interface bsi_res_if;
	import bsi_pkg::*;

	logic         valid;
	logic         ready;
	word_t        popped_value;
	word_t        top_value;
	word_t        bottom_value;
	entry_count_t entry_count;
	status_t      status;
	logic         is_empty;
	logic         is_full;

	modport source (
		output valid, output popped_value, output top_value, output bottom_value,
		output entry_count, output status, output is_empty, output is_full,
		input ready
	);
	modport sink (
		input valid, input popped_value, input top_value, input bottom_value,
		input entry_count, input status, input is_empty, input is_full,
		output ready
	);

endinterface

/* src/bounded_stack_with_insert_unit.sv */
// ----------------------------------------------------------------------------
// Bounded stack with insert
// LIFO of signed words with push, pop, insert at position and query.
//
//   channel  dir  payload
//   req      in   opcode, value, position
//   res      out  popped_value, top_value, bottom_value, entry_count,
//                 status, is_empty, is_full
//
// Push, query and failed operations go through EXEC and DONE; a pop that
// leaves entries also reads the new top in TOP_WT. Insert below the top
// moves the entries up one at a time through storage, read then write.
// The next request is taken while a result waits on res; the unit stalls
// in its final state until the result register is free.
// Reset clears the count and the sequencer; storage needs no clearing.
// ----------------------------------------------------------------------------
`include "bounded_stack_with_insert_unit_assert.svh"

module bounded_stack_with_insert_unit (
	input logic clk,
	input logic arst_n,
	bsi_req_if.sink   req,
	bsi_res_if.source res
);
	import bsi_pkg::*;

	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_EXEC   = 3'd1;
	localparam logic [2:0] S_SH_RD  = 3'd2;
	localparam logic [2:0] S_SH_WR  = 3'd3;
	localparam logic [2:0] S_INS_WR = 3'd4;
	localparam logic [2:0] S_TOP_WT = 3'd5;
	localparam logic [2:0] S_DONE   = 3'd6;

	localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);
	localparam logic [CNT_W-1:0] CNT_ONE  = CNT_W'(1);

	logic [2:0]        state_q;
	logic [CNT_W-1:0]  count_q;
	logic              res_vld_q;

	opcode_t           op_q;
	word_t             value_q;
	position_t         position_q;
	logic [ADDR_W-1:0] idx_q;
	logic [ADDR_W-1:0] posc_q;
	word_t             top_q;
	word_t             bottom_q;
	word_t             popped_q;
	status_t           status_q;

	word_t             res_popped_q;
	word_t             res_top_q;
	word_t             res_bottom_q;
	entry_count_t      res_count_q;
	status_t           res_status_q;
	logic              res_empty_q;
	logic              res_full_q;

	logic              ram_we;
	logic [ADDR_W-1:0] ram_waddr;
	word_t             ram_wdata;
	logic [ADDR_W-1:0] ram_raddr;
	word_t             ram_rdata;

	logic              accept;
	logic              load;
	logic              full;
	logic              empty;
	logic [CNT_W-1:0]  pos_ext;
	logic [CNT_W-1:0]  pos_clamp;
	logic [CNT_W-1:0]  cnt_dec;
	logic [ADDR_W-1:0] idx_dec;

	bsi_ram u_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign req.ready = (state_q == S_IDLE);
	assign accept    = req.valid && req.ready;
	assign load      = (state_q == S_DONE) && (!res_vld_q || res.ready);
	assign full      = (count_q == CNT_FULL);
	assign empty     = (count_q == '0);
	assign pos_ext   = CNT_W'(position_q);
	assign pos_clamp = (pos_ext > count_q) ? count_q : pos_ext;
	assign cnt_dec   = count_q - CNT_ONE;
	assign idx_dec   = idx_q - ADDR_W'(1);

	always_comb begin
		ram_we    = 1'b0;
		ram_waddr = count_q[ADDR_W-1:0];
		ram_wdata = value_q;
		ram_raddr = idx_dec;
		case (state_q)
			S_EXEC: begin
				if (op_q == OP_POP) begin
					ram_raddr = cnt_dec[ADDR_W-1:0] - ADDR_W'(1);
				end else if (!full && (op_q == OP_PUSH ||
						(op_q == OP_INSERT && pos_clamp == count_q))) begin
					ram_we = 1'b1;
				end
			end
			S_SH_WR: begin
				ram_we    = 1'b1;
				ram_waddr = idx_q;
				ram_wdata = ram_rdata;
			end
			S_INS_WR: begin
				ram_we    = 1'b1;
				ram_waddr = posc_q;
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			count_q   <= '0;
			res_vld_q <= 1'b0;
		end else begin
			if (load) begin
				res_vld_q <= 1'b1;
			end else if (res.ready) begin
				res_vld_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					state_q <= S_DONE;
					case (op_q)
						OP_PUSH: begin
							if (!full) begin
								count_q <= count_q + CNT_ONE;
							end
						end
						OP_POP: begin
							if (!empty) begin
								count_q <= cnt_dec;
								if (cnt_dec != '0) begin
									state_q <= S_TOP_WT;
								end
							end
						end
						OP_INSERT: begin
							if (!full) begin
								count_q <= count_q + CNT_ONE;
								if (pos_clamp != count_q) begin
									state_q <= S_SH_RD;
								end
							end
						end
						default: begin
						end
					endcase
				end
				S_SH_RD: begin
					state_q <= S_SH_WR;
				end
				S_SH_WR: begin
					state_q <= (idx_dec == posc_q) ? S_INS_WR : S_SH_RD;
				end
				S_INS_WR: begin
					state_q <= S_DONE;
				end
				S_TOP_WT: begin
					state_q <= S_DONE;
				end
				S_DONE: begin
					if (load) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			op_q       <= req.opcode;
			value_q    <= req.value;
			position_q <= req.position;
			popped_q   <= EMPTY_WORD;
			status_q   <= ST_OK;
		end
		case (state_q)
			S_EXEC: begin
				idx_q  <= count_q[ADDR_W-1:0];
				posc_q <= pos_clamp[ADDR_W-1:0];
				case (op_q)
					OP_PUSH: begin
						if (full) begin
							status_q <= ST_OVERFLOW;
						end else begin
							top_q <= value_q;
							if (empty) begin
								bottom_q <= value_q;
							end
						end
					end
					OP_POP: begin
						if (empty) begin
							status_q <= ST_UNDERFLOW;
						end else begin
							popped_q <= top_q;
						end
					end
					OP_INSERT: begin
						if (full) begin
							status_q <= ST_OVERFLOW;
						end else begin
							if (pos_clamp == count_q) begin
								top_q <= value_q;
							end
							if (pos_clamp == '0) begin
								bottom_q <= value_q;
							end
						end
					end
					default: begin
					end
				endcase
			end
			S_SH_WR: begin
				idx_q <= idx_dec;
			end
			S_TOP_WT: begin
				top_q <= ram_rdata;
			end
			default: begin
			end
		endcase
		if (load) begin
			res_popped_q <= popped_q;
			res_top_q    <= empty ? EMPTY_WORD : top_q;
			res_bottom_q <= empty ? EMPTY_WORD : bottom_q;
			res_count_q  <= entry_count_t'(count_q);
			res_status_q <= status_q;
			res_empty_q  <= empty;
			res_full_q   <= full;
		end
	end

	assign res.valid        = res_vld_q;
	assign res.popped_value = res_popped_q;
	assign res.top_value    = res_top_q;
	assign res.bottom_value = res_bottom_q;
	assign res.entry_count  = res_count_q;
	assign res.status       = res_status_q;
	assign res.is_empty     = res_empty_q;
	assign res.is_full      = res_full_q;

	`BSI_ASSERT_SAME(a_count_bound, clk, arst_n, 1'b1, count_q <= CNT_FULL)
	`BSI_ASSERT_NEXT(a_accept_exec, clk, arst_n, accept, state_q == S_EXEC)
	`BSI_ASSERT_SAME(a_ovf_full, clk, arst_n, res.valid && res.status == ST_OVERFLOW, res.is_full)
	`BSI_ASSERT_SAME(a_unf_empty, clk, arst_n, res.valid && res.status == ST_UNDERFLOW, res.is_empty)

endmodule

/* src/bsi_ram.sv */
// ----------------------------------------------------------------------------
// Stack storage
// One write port and one registered read port over the stack entries.
// ----------------------------------------------------------------------------
module bsi_ram (
	input  logic                      clk,
	input  logic                      we,
	input  logic [bsi_pkg::ADDR_W-1:0] waddr,
	input  bsi_pkg::word_t            wdata,
	input  logic [bsi_pkg::ADDR_W-1:0] raddr,
	output bsi_pkg::word_t            rdata
);
	import bsi_pkg::*;

	word_t mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= mem_q[raddr];
	end

endmodule
